// ===== design/sdwt_pkg.sv =====
// shared constants, command types and widths for the sleep deadline wakeup timer
// no dependencies; every other design file depends on this package
package sdwt_pkg;

  // table size and field widths
  localparam int SlotCount = 16;
  localparam int SlotIdxW  = $clog2(SlotCount);
  localparam int SlotW     = 4;
  localparam int MsW       = 20;
  localparam int RateW     = 11;
  localparam int CountW    = 48;
  localparam int MaskW     = 16;
  localparam int PeriodW   = 4;

  // rate register limits
  localparam logic [RateW-1:0] RateMin   = RateW'(1);
  localparam logic [RateW-1:0] RateMax   = RateW'(1193);
  localparam logic [RateW-1:0] RateReset = RateW'(100);

  // rate / 100 as a reciprocal multiply, exact for rates below 2048
  localparam logic [RateW-1:0] PeriodMul   = RateW'(1311);
  localparam int               PeriodShift = 17;

  // product / 1000 as a reciprocal multiply, exact for products below 2^31
  localparam int               ProdW      = RateW + MsW;
  localparam int               RecipW     = 32;
  localparam logic [RecipW-1:0] RecipMul  = 32'd2199023256;
  localparam int               RecipShift = 41;
  localparam int               TicksW     = 21;

  // command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // action codes of the request
  localparam logic ActTick  = 1'b0;
  localparam logic ActSleep = 1'b1;

  typedef enum logic [1:0] {
    CmdTick,
    CmdSleepSlot,
    CmdSleepKernel,
    CmdSleepNone
  } sdwt_cmd_e;

  typedef struct packed {
    sdwt_cmd_e             kind;
    logic [SlotIdxW-1:0]   slot;
    logic [MsW-1:0]        sleep_ms;
  } sdwt_cmd_t;

endpackage

// ===== design/sdwt_intf.sv =====
// request and result channel interfaces of the sleep deadline wakeup timer
// depends on sdwt_pkg for field widths
interface sdwt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [sdwt_pkg::SlotW-1:0]    process_slot;
  logic [sdwt_pkg::MsW-1:0]      sleep_ms;

  modport source (output valid, action, process_slot, sleep_ms, input ready);
  modport sink   (input valid, action, process_slot, sleep_ms, output ready);
endinterface

interface sdwt_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdwt_pkg::MaskW-1:0]    woken_mask;
  logic                          schedule_now;
  logic [sdwt_pkg::CountW-1:0]   tick_count;
  logic [sdwt_pkg::CountW-1:0]   wake_tick;

  modport source (output valid, woken_mask, schedule_now, tick_count, wake_tick, input ready);
  modport sink   (input valid, woken_mask, schedule_now, tick_count, wake_tick, output ready);
endinterface

// ===== design/sdwt_front.sv =====
// front end: accepts requests, classifies them and queues commands for the back end
// depends on sdwt_pkg and sdwt_in_if
module sdwt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sdwt_in_if.sink               in_if,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output sdwt_pkg::sdwt_cmd_t   cmd_o
);
  import sdwt_pkg::*;

  sdwt_cmd_t          q_mem [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  sdwt_cmd_t          cmd_new;
  logic               push, pop;

  // classify the request
  always_comb begin
    cmd_new.sleep_ms = in_if.sleep_ms;
    cmd_new.slot     = SlotIdxW'(in_if.process_slot);
    if (in_if.action == ActTick) begin
      cmd_new.kind = CmdTick;
    end else if (in_if.process_slot == SlotW'(0)) begin
      cmd_new.kind = CmdSleepKernel;
    end else if (32'(in_if.process_slot) < SlotCount) begin
      cmd_new.kind = CmdSleepSlot;
    end else begin
      cmd_new.kind = CmdSleepNone;
    end
  end

  // queue handshakes
  assign in_if.ready = (cnt_q != QCntW'(QueueDepth));
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== design/sdwt_back.sv =====
// back end: tick count, deadline table scan, sleep deadline arithmetic, result register
// depends on sdwt_pkg and sdwt_out_if
module sdwt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sdwt_pkg::RateW-1:0] cfg_wdata_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  sdwt_pkg::sdwt_cmd_t        cmd_i,
  sdwt_out_if.source                 out_if
);
  import sdwt_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StWake = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam int MulW = ProdW + RecipW;

  logic [2:0]              state_q, state_d;
  logic [RateW-1:0]        rate_q;
  logic [PeriodW-1:0]      period_q;
  logic [CountW-1:0]       count_q;
  logic [PeriodW-1:0]      phase_q;
  logic [SlotCount-1:0]    sleeping_q;
  logic [CountW-1:0]       deadline_q [SlotCount];
  logic [SlotIdxW-1:0]     scan_q;
  logic                    out_valid_q;

  sdwt_cmd_e               kind_q;
  logic [SlotIdxW-1:0]     slot_q;
  logic [MaskW-1:0]        mask_q;
  logic                    sched_q;
  logic [ProdW-1:0]        prod_q;
  logic [TicksW-1:0]       ticks_q;
  logic [CountW-1:0]       wake_q;
  logic [MaskW-1:0]        out_mask_q;
  logic                    out_sched_q;
  logic [CountW-1:0]       out_count_q;
  logic [CountW-1:0]       out_wake_q;

  logic [RateW-1:0]        rate_clamped;
  logic [2*RateW-1:0]      period_full;
  logic [PeriodW-1:0]      period_raw;
  logic [PeriodW-1:0]      period_new;
  logic [PeriodW:0]        phase_inc;
  logic                    sched_hit;
  logic                    hit;
  logic                    scan_last;
  logic [MulW-1:0]         div_full;
  logic [TicksW-1:0]       ticks_eff;
  logic [CountW-1:0]       wake_next;
  logic                    out_free;
  logic                    is_tick;

  // clamp the written rate and derive the scheduling period
  always_comb begin
    if (cfg_wdata_i < RateMin) begin
      rate_clamped = RateMin;
    end else if (cfg_wdata_i > RateMax) begin
      rate_clamped = RateMax;
    end else begin
      rate_clamped = cfg_wdata_i;
    end
    period_full = (2*RateW)'(rate_clamped) * (2*RateW)'(PeriodMul);
    period_raw  = PeriodW'(period_full >> PeriodShift);
    period_new  = (period_raw == '0) ? PeriodW'(1) : period_raw;
  end

  // schedule phase and deadline compare for the slot under scan
  assign phase_inc = {1'b0, phase_q} + (PeriodW+1)'(1);
  assign sched_hit = (phase_inc >= {1'b0, period_q});
  assign hit       = sleeping_q[scan_q] && (deadline_q[scan_q] <= count_q);
  assign scan_last = (scan_q == SlotIdxW'(SlotCount - 1));

  // ticks = product / 1000 through the reciprocal
  assign div_full  = MulW'(prod_q) * MulW'(RecipMul);
  assign ticks_eff = (kind_q == CmdSleepKernel && ticks_q == '0) ? TicksW'(1) : ticks_q;
  assign wake_next = count_q + CountW'(ticks_eff);

  assign out_free    = !out_valid_q || out_if.ready;
  assign cmd_ready_o = (state_q == StIdle);
  assign is_tick     = (kind_q == CmdTick);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == CmdTick) ? StScan : StDiv;
        end
      end
      StScan: begin
        if (scan_last) begin
          state_d = StOut;
        end
      end
      StDiv:  state_d = StWake;
      StWake: state_d = StOut;
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rate_q      <= RateReset;
      period_q    <= PeriodW'(1);
      count_q     <= '0;
      phase_q     <= '0;
      sleeping_q  <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rate_q   <= rate_clamped;
        period_q <= period_new;
      end
      if (state_q == StIdle && cmd_valid_i && cmd_i.kind == CmdTick) begin
        count_q <= count_q + CountW'(1);
        phase_q <= sched_hit ? '0 : phase_inc[PeriodW-1:0];
        scan_q  <= '0;
      end
      if (state_q == StScan) begin
        if (hit) begin
          sleeping_q[scan_q] <= 1'b0;
        end
        scan_q <= scan_q + SlotIdxW'(1);
      end
      if (state_q == StWake && kind_q == CmdSleepSlot) begin
        sleeping_q[slot_q] <= 1'b1;
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath and deadline table
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i) begin
      kind_q  <= cmd_i.kind;
      slot_q  <= cmd_i.slot;
      mask_q  <= '0;
      sched_q <= sched_hit;
      prod_q  <= ProdW'(rate_q) * ProdW'(cmd_i.sleep_ms);
    end
    if (state_q == StScan && hit) begin
      mask_q <= mask_q | (MaskW'(1) << scan_q);
    end
    if (state_q == StDiv) begin
      ticks_q <= TicksW'(div_full >> RecipShift);
    end
    if (state_q == StWake) begin
      wake_q <= wake_next;
      if (kind_q == CmdSleepSlot) begin
        deadline_q[slot_q] <= wake_next;
      end
    end
    if (state_q == StOut && out_free) begin
      out_mask_q  <= is_tick ? mask_q : '0;
      out_sched_q <= is_tick ? sched_q : 1'b0;
      out_count_q <= count_q;
      out_wake_q  <= is_tick ? '0 : wake_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.woken_mask   = out_mask_q;
  assign out_if.schedule_now = out_sched_q;
  assign out_if.tick_count   = out_count_q;
  assign out_if.wake_tick    = out_wake_q;

endmodule

// ===== design/sleep_deadline_wakeup_timer_top.sv =====
// top level of the sleep deadline wakeup timer: front end, command queue, back end
// depends on sdwt_pkg, sdwt_in_if, sdwt_out_if, sdwt_front and sdwt_back
//
// A tick request advances the 48-bit tick count, wakes every sleeping slot whose
// deadline is at or below the new count (reported as woken_mask) and raises
// schedule_now once every max(1, rate/100) ticks. A sleep request for a slot other
// than 0 stores the deadline count + rate*ms/1000 for that slot; for slot 0 only the
// wake tick is reported, at least one tick ahead. Requests are taken into a two-entry
// command queue one per cycle until it fills. The execution side holds one request
// at a time: a tick runs the deadline scan, which compares one slot per cycle, and a
// sleep request passes the states StDiv and StWake for the two registered multiplies
// of the rate product and the divide by 1000. The result register lets the next
// request start while a result waits to be taken. The tick rate register is written
// with cfg_we_i and is clamped to 1..1193.
module sleep_deadline_wakeup_timer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sdwt_pkg::RateW-1:0] cfg_wdata_i,
  sdwt_in_if.sink                    in_if,
  sdwt_out_if.source                 out_if
);
  import sdwt_pkg::*;

  logic      cmd_valid;
  logic      cmd_ready;
  sdwt_cmd_t cmd;

  // request intake and queue
  sdwt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // execution and result register
  sdwt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_if      (out_if)
  );

  // a result that woke slots is a tick result and carries no wake tick
  a_mask_no_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.woken_mask != '0) |-> out_if.wake_tick == '0)
    else $error("woken slots reported with a wake tick");

  // a scheduling flag only comes with a tick result
  a_sched_no_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.schedule_now |-> out_if.wake_tick == '0)
    else $error("schedule flag reported with a wake tick");

  // a queued command stays offered until the back end takes it
  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid)
    else $error("queued command lost before dispatch");

endmodule

// ===== tb/sv/sdwt_checker.sv =====
// result checker for the sleep deadline wakeup timer: mirrors the tick count,
// the slot table and the schedule phase, and compares every result taken
// depends on sdwt_pkg and the channel interfaces in sdwt_intf.sv
module sdwt_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sdwt_pkg::RateW-1:0] cfg_wdata_i,
  sdwt_in_if                         req_mon,
  sdwt_out_if                        res_mon,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdwt_pkg::*;

  typedef struct packed {
    logic [MaskW-1:0]  woken;
    logic              sched;
    logic [CountW-1:0] count;
    logic [CountW-1:0] wake;
  } timer_result_t;

  // mirrored timer state
  logic [RateW-1:0]   rate_hz;
  logic [CountW-1:0]  tick_now;
  logic [SlotCount-1:0] asleep;
  logic [CountW-1:0]  wake_deadline [SlotCount];
  logic [PeriodW-1:0] sched_phase;

  timer_result_t expected_results [$];
  int mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string field, input logic [CountW-1:0] got,
                                 input logic [CountW-1:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  function automatic logic [RateW-1:0] clamp_rate(input logic [RateW-1:0] raw);
    if (raw < RateMin) return RateMin;
    if (raw > RateMax) return RateMax;
    return raw;
  endfunction

  // one request applied to the mirrored state, giving the result it should produce
  task automatic advance_timer(input logic act, input logic [SlotW-1:0] slot,
                               input logic [MsW-1:0] ms, output timer_result_t res);
    int unsigned period;
    logic [63:0] ticks;
    res = '0;
    if (act == ActTick) begin
      tick_now = tick_now + 1'b1;
      for (int s = 0; s < SlotCount; s++) begin
        if (asleep[s] && wake_deadline[s] <= tick_now) begin
          asleep[s] = 1'b0;
          if (s < MaskW) res.woken[s] = 1'b1;
        end
      end
      period = rate_hz / 100;
      if (period == 0) period = 1;
      if (int'(sched_phase) + 1 >= period) begin
        res.sched   = 1'b1;
        sched_phase = '0;
      end else begin
        sched_phase = sched_phase + 1'b1;
      end
      res.count = tick_now;
    end else begin
      ticks = (64'(rate_hz) * 64'(ms)) / 1000;
      // the kernel always sleeps at least one tick and owns no table entry
      if (slot == 0) begin
        if (ticks == 0) ticks = 1;
        res.wake = tick_now + ticks[CountW-1:0];
      end else begin
        res.wake = tick_now + ticks[CountW-1:0];
        if (int'(slot) < SlotCount) begin
          wake_deadline[slot] = res.wake;
          asleep[slot]        = 1'b1;
        end
      end
      res.count = tick_now;
    end
  endtask

  task automatic check_result(input timer_result_t want);
    if (res_mon.woken_mask !== want.woken)
      report_mismatch("woken_mask", CountW'(res_mon.woken_mask), CountW'(want.woken));
    if (res_mon.schedule_now !== want.sched)
      report_mismatch("schedule_now", CountW'(res_mon.schedule_now), CountW'(want.sched));
    if (res_mon.tick_count !== want.count)
      report_mismatch("tick_count", res_mon.tick_count, want.count);
    if (res_mon.wake_tick !== want.wake)
      report_mismatch("wake_tick", res_mon.wake_tick, want.wake);
  endtask

  // watch the register port and both channels at every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t res;
    if (!rst_ni) begin
      rate_hz     = RateReset;
      tick_now    = '0;
      asleep      = '0;
      sched_phase = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) rate_hz = clamp_rate(cfg_wdata_i);
      // results leave before any request taken at this edge can produce one
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", res_mon.tick_count, '0);
        end else begin
          check_result(expected_results.pop_front());
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        advance_timer(req_mon.action, req_mon.process_slot, req_mon.sleep_ms, res);
        expected_results.push_back(res);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the sleep deadline wakeup timer: clock, reset, request
// stimulus, result back-pressure and the verdict
// depends on sdwt_pkg, sdwt_intf.sv, the timer top level and sdwt_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdwt_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 3 * (SlotCount + 2) + 8;
  localparam int PhaseItems  = 225;

  typedef enum int {StallNone, StallLight, StallHeavy, StallRhythm} stall_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [RateW-1:0] cfg_wdata;
  int fail_count;
  int pending;
  int cycles = 0;
  int rate_now = int'(RateReset);

  sdwt_in_if  req_ch ();
  sdwt_out_if res_ch ();

  sleep_deadline_wakeup_timer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (req_ch),
    .out_if      (res_ch)
  );

  sdwt_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon      (req_ch),
    .res_mon      (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure, in stretches of one mode each
  initial begin : result_stall
    stall_mode_e mode;
    int stretch;
    int beat = 0;
    res_ch.ready = 1'b0;
    forever begin
      mode    = stall_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(4, 64);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          StallNone:  res_ch.ready <= 1'b1;
          StallLight: res_ch.ready <= ($urandom_range(0, 3) != 0);
          StallHeavy: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    res_ch.ready <= ((beat % 5) < 3);
        endcase
        beat++;
      end
    end
  end

  // one request, held until taken
  task automatic send_request(input logic act, input logic [SlotW-1:0] slot,
                              input logic [MsW-1:0] ms);
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.process_slot <= slot;
    req_ch.sleep_ms     <= ms;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
  endtask

  // sender pauses until every result is back
  task automatic wait_all_results();
    idle_cycles(1);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RateW-1:0] value);
    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (value < RateMin) rate_now = int'(RateMin);
    else if (value > RateMax) rate_now = int'(RateMax);
    else rate_now = int'(value);
  endtask

  // mostly short sleeps so that slots wake within a few ticks, now and then any length
  function automatic logic [MsW-1:0] pick_ms();
    int lim;
    if ($urandom_range(0, 9) == 0) return MsW'($urandom);
    lim = 12000 / rate_now + 2;
    return MsW'($urandom_range(0, lim));
  endfunction

  task automatic random_requests(input int n);
    int sent = 0;
    int burst;
    logic act;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n; i++) begin
        act = ($urandom_range(0, 99) < 45) ? ActSleep : ActTick;
        send_request(act, SlotW'($urandom), pick_ms());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      if ($urandom_range(0, 39) == 0) wait_all_results();
    end
  endtask

  // stimulus and verdict
  initial begin
    req_ch.valid        = 1'b0;
    req_ch.action       = ActTick;
    req_ch.process_slot = '0;
    req_ch.sleep_ms     = '0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset rate
    send_request(ActTick, '0, '0);
    send_request(ActSleep, 4'd0, '0);          // kernel, one-tick minimum
    send_request(ActSleep, 4'd1, '0);          // zero-length, wakes next tick
    send_request(ActSleep, 4'd15, '1);         // longest sleep
    send_request(ActSleep, 4'd2, 20'd30);
    send_request(ActSleep, 4'd2, 20'd10);      // replaces the earlier deadline
    send_request(ActSleep, 4'd3, 20'd20);
    send_request(ActTick, 4'hF, '1);
    send_request(ActTick, '0, '0);
    send_request(ActTick, 4'h5, 20'h55555);
    send_request(ActTick, 4'hA, 20'hAAAAA);
    send_request(ActSleep, 4'd15, '0);         // far deadline cut short
    send_request(ActSleep, 4'd0, '1);
    send_request(ActSleep, 4'd7, 20'h55555);
    send_request(ActSleep, 4'd8, 20'hAAAAA);
    send_request(ActTick, '0, '0);
    send_request(ActTick, '0, '0);
    wait_all_results();

    // random part over several rates, extremes and clamping included
    random_requests(PhaseItems);
    write_rate(RateW'(1193));
    random_requests(PhaseItems);
    write_rate(RateW'(250));               // phase may already be past the new period
    random_requests(PhaseItems);
    write_rate('0);
    random_requests(PhaseItems);
    write_rate('1);
    random_requests(PhaseItems);
    write_rate(RateW'(99));
    random_requests(PhaseItems);
    write_rate(RateW'(1000));
    random_requests(PhaseItems);
    write_rate(RateW'($urandom_range(1, 1193)));
    random_requests(PhaseItems);

    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
